### rtl/string_pool_intern_overlap_defines.svh
// Assertion macros shared by the string pool modules.
`ifndef STRING_POOL_INTERN_OVERLAP_DEFINES_SVH
`define STRING_POOL_INTERN_OVERLAP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SPIO_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define SPIO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define SPIO_ASSERT(lbl, expr, msg)
`define SPIO_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

### rtl/spio_pkg.sv
`timescale 1ns / 1ps
package spio_pkg;

  localparam int CHAR_W   = 8;
  localparam int OFFSET_W = 11;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_LONG = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_CMP,
    S_APPEND,
    S_COPY_RD,
    S_COPY_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    step_match;
    logic    step_miss;
    logic    copy_init;
    logic    copy_rd;
    logic    copy_step;
    logic    commit;
    logic    res_set;
    status_t res_code;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic too_long;
    logic len_hit;
    logic tail_hit;
    logic match;
    logic full;
    logic copy_end;
  } sts_t;

endpackage

### rtl/spio_if.sv
`timescale 1ns / 1ps
interface spio_char_if;
  logic                        valid;
  logic                        ready;
  logic [spio_pkg::CHAR_W-1:0] char_in;
  logic                        last_char;
  modport source(output valid, char_in, last_char, input ready);
  modport sink(input valid, char_in, last_char, output ready);
endinterface

interface spio_result_if;
  logic                          valid;
  logic                          ready;
  logic [spio_pkg::OFFSET_W-1:0] pool_offset;
  logic [spio_pkg::STATUS_W-1:0] status;
  logic [spio_pkg::OFFSET_W-1:0] pool_used;
  modport source(output valid, pool_offset, status, pool_used, input ready);
  modport sink(input valid, pool_offset, status, pool_used, output ready);
endinterface

### rtl/spio_ram.sv
`timescale 1ns / 1ps
module spio_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/spio_dp.sv
`timescale 1ns / 1ps
`include "string_pool_intern_overlap_defines.svh"
module spio_dp #(
  parameter int POOL_BYTES = 1024,
  parameter int MAX_STRING = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  spio_pkg::cmd_t                cmd,
  output spio_pkg::sts_t                sts,
  input  logic [spio_pkg::CHAR_W-1:0]   char_in,
  input  logic                          last_char,
  output logic [spio_pkg::OFFSET_W-1:0] pool_offset,
  output logic [spio_pkg::STATUS_W-1:0] status,
  output logic [spio_pkg::OFFSET_W-1:0] pool_used
);

  localparam int AW = $clog2(POOL_BYTES);
  localparam int LW = $clog2(POOL_BYTES + 1);
  localparam int BW = $clog2(MAX_STRING);
  localparam int CW = $clog2(MAX_STRING + 1);
  localparam int XW = (LW > CW) ? LW : CW;
  localparam int SW = XW + 1;

  logic [LW-1:0] pool_length;
  logic [CW-1:0] count;
  logic          overflow;
  logic [CW-1:0] len;
  logic [LW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] k;
  logic [LW-1:0] wa;
  spio_pkg::status_t res_status;

  logic [LW-1:0]               tail;
  logic [SW-1:0]               rd_sum;
  logic [spio_pkg::CHAR_W-1:0] pool_rdata;
  logic [spio_pkg::CHAR_W-1:0] buf_rdata;
  logic                        buf_we;
  logic [BW-1:0]               buf_raddr;

  assign tail      = pool_length - i;
  assign rd_sum    = SW'(i) + SW'(j);
  assign buf_we    = cmd.accept && (count < CW'(MAX_STRING));
  assign buf_raddr = cmd.copy_rd ? k[BW-1:0] : j[BW-1:0];

  spio_ram #(.WIDTH(spio_pkg::CHAR_W), .DEPTH(MAX_STRING)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (count[BW-1:0]),
    .wdata (char_in),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  spio_ram #(.WIDTH(spio_pkg::CHAR_W), .DEPTH(POOL_BYTES)) u_pool (
    .clk   (clk),
    .we    (cmd.copy_step),
    .waddr (wa[AW-1:0]),
    .wdata (buf_rdata),
    .raddr (rd_sum[AW-1:0]),
    .rdata (pool_rdata)
  );

  always_comb begin
    sts.last     = last_char;
    sts.too_long = overflow || (count == CW'(MAX_STRING));
    sts.len_hit  = (j == len);
    sts.tail_hit = (XW'(j) == XW'(tail));
    sts.match    = (pool_rdata == buf_rdata);
    sts.full     = (SW'(pool_length) + SW'(len)) > SW'(POOL_BYTES);
    sts.copy_end = (k == len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_length <= '0;
      count       <= '0;
      overflow    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (last_char) begin
          count    <= '0;
          overflow <= 1'b0;
        end else if (count < CW'(MAX_STRING)) begin
          count <= count + 1'b1;
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.commit) begin
        pool_length <= wa;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      len <= count + 1'b1;
      i   <= '0;
      j   <= '0;
    end
    if (cmd.step_match) begin
      j <= j + 1'b1;
    end
    if (cmd.step_miss) begin
      i <= i + 1'b1;
      j <= '0;
    end
    if (cmd.copy_init) begin
      k  <= j;
      wa <= pool_length;
    end
    if (cmd.copy_step) begin
      k  <= k + 1'b1;
      wa <= wa + 1'b1;
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_code;
    end
    if (cmd.load_out) begin
      pool_offset <= (res_status == spio_pkg::ST_OK) ? spio_pkg::OFFSET_W'(i) : '0;
      status      <= res_status;
      pool_used   <= spio_pkg::OFFSET_W'(pool_length);
    end
  end

  `SPIO_ASSERT(a_pool_bound, pool_length <= LW'(POOL_BYTES), "pool length beyond pool size")
  `SPIO_ASSERT(a_count_bound, count <= CW'(MAX_STRING), "string count beyond buffer")
  `SPIO_ASSERT_IMP(a_scan_tail, cmd.step_match || cmd.step_miss, i < pool_length, "scan past tail")
  `SPIO_ASSERT_IMP(a_copy_fit, cmd.copy_step, wa < LW'(POOL_BYTES), "append past pool end")

endmodule

### rtl/spio_ctrl.sv
`timescale 1ns / 1ps
`include "string_pool_intern_overlap_defines.svh"
module spio_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  spio_pkg::sts_t sts,
  output spio_pkg::cmd_t cmd
);

  spio_pkg::state_t state, state_next;
  logic             slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spio_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      spio_pkg::S_IDLE: begin
        if (in_valid && sts.last) begin
          state_next = sts.too_long ? spio_pkg::S_DONE : spio_pkg::S_CHECK;
        end
      end
      spio_pkg::S_CHECK: begin
        if (sts.len_hit) begin
          state_next = spio_pkg::S_DONE;
        end else if (sts.tail_hit) begin
          state_next = spio_pkg::S_APPEND;
        end else begin
          state_next = spio_pkg::S_CMP;
        end
      end
      spio_pkg::S_CMP:     state_next = spio_pkg::S_CHECK;
      spio_pkg::S_APPEND:  state_next = sts.full ? spio_pkg::S_DONE : spio_pkg::S_COPY_RD;
      spio_pkg::S_COPY_RD: state_next = sts.copy_end ? spio_pkg::S_DONE : spio_pkg::S_COPY_WR;
      spio_pkg::S_COPY_WR: state_next = spio_pkg::S_COPY_RD;
      spio_pkg::S_DONE: begin
        if (slot_free) begin
          state_next = spio_pkg::S_IDLE;
        end
      end
      default: state_next = spio_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.res_code = spio_pkg::ST_OK;
    in_ready = 1'b0;
    unique case (state)
      spio_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.last) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = sts.too_long ? spio_pkg::ST_LONG : spio_pkg::ST_OK;
        end
      end
      spio_pkg::S_CHECK: ;
      spio_pkg::S_CMP: begin
        cmd.step_match = sts.match;
        cmd.step_miss  = !sts.match;
      end
      spio_pkg::S_APPEND: begin
        cmd.copy_init = !sts.full;
        cmd.res_set   = sts.full;
        cmd.res_code  = spio_pkg::ST_FULL;
      end
      spio_pkg::S_COPY_RD: begin
        cmd.copy_rd = 1'b1;
        cmd.commit  = sts.copy_end;
      end
      spio_pkg::S_COPY_WR: cmd.copy_step = 1'b1;
      spio_pkg::S_DONE:    cmd.load_out = slot_free;
      default: ;
    endcase
  end

  `SPIO_ASSERT_IMP(a_load_slot, cmd.load_out, !out_valid || out_ready, "result overwritten")
  `SPIO_ASSERT_IMP(a_copy_pair, state == spio_pkg::S_COPY_WR, cmd.copy_step && !in_ready, "copy stalled")
  `SPIO_ASSERT_IMP(a_idle_ready, state == spio_pkg::S_IDLE, in_ready, "idle not ready")

endmodule

### rtl/string_pool_intern_overlap.sv
`timescale 1ns / 1ps
// String pool interning block.
// in_chan carries one byte of a string per request; last_char closes it.
// out_chan returns one result per closed string: start offset, status
// (ok, pool full, string too long) and pool bytes in use afterwards.
// Bytes that do not close a string are taken without a stall.
// A closing byte starts a scan of the pool from offset 0: each compared
// byte is a registered read of the pool and string memories, and each
// miss restarts at the next offset. Appending copies the new bytes into
// the pool one at a time. A too-long string is answered without a scan.
// The scan engine is shared, so one string is worked on at a time; in_chan
// is not ready while a scan or append runs.
// Reset empties the pool and the string buffer at once; no clearing pass.
// The output register holds a result until taken; a new string's bytes
// are accepted meanwhile, and the next result waits for the slot.
module string_pool_intern_overlap #(
  parameter int POOL_BYTES = 1024,
  parameter int MAX_STRING = 64
) (
  input logic clk,
  input logic rst,
  spio_char_if.sink     in_chan,
  spio_result_if.source out_chan
);

  spio_pkg::cmd_t cmd;
  spio_pkg::sts_t sts;

  spio_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spio_dp #(.POOL_BYTES(POOL_BYTES), .MAX_STRING(MAX_STRING)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .char_in     (in_chan.char_in),
    .last_char   (in_chan.last_char),
    .pool_offset (out_chan.pool_offset),
    .status      (out_chan.status),
    .pool_used   (out_chan.pool_used)
  );

endmodule
